// File: design/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants for the concatenate-and-sort block
// Item formats, default capacity and sequencer states.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int MAX_ELEMENTS_DEF = 32;
  localparam int DATA_W           = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
    logic                     overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// File: design/cas_store.sv
// ----------------------------------------------------------------------------
// cas_store: element store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module cas_store #(
  parameter int MAX_ELEMENTS = cas_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]    waddr,
  input  logic [cas_pkg::DATA_W-1:0]         wdata,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]    raddr,
  output logic [cas_pkg::DATA_W-1:0]         rdata
);

  logic [cas_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/cas_ctrl.sv
// ----------------------------------------------------------------------------
// cas_ctrl: load and sort sequencer
// Loads items into the store, runs the exchange sort through one signed
// comparator and emits each position once it is final.
// ----------------------------------------------------------------------------
module cas_ctrl #(
  parameter int MAX_ELEMENTS = cas_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cas_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cas_pkg::out_item_t                 out_item,
  output logic                               mem_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0]    mem_waddr,
  output logic [cas_pkg::DATA_W-1:0]         mem_wdata,
  output logic [$clog2(MAX_ELEMENTS)-1:0]    mem_raddr,
  input  logic [cas_pkg::DATA_W-1:0]         mem_rdata
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  cas_pkg::state_t state, state_next;

  logic [CW-1:0]                    count, count_next;
  logic                             dropped, dropped_next;
  logic [AW-1:0]                    idx_i, idx_i_next;
  logic [AW-1:0]                    idx_j, idx_j_next;
  logic signed [cas_pkg::DATA_W-1:0] cur, cur_next;
  logic                             out_valid_next;
  cas_pkg::out_item_t               out_item_next;

  logic in_acc;
  logic out_free;
  logic i_more;
  logic j_more;
  logic i_final;
  logic swap;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign i_more   = (CW'(idx_i) + CW'(1)) < count;
  assign i_final  = (CW'(idx_i) + CW'(1)) == count;
  assign j_more   = (CW'(idx_j) + CW'(1)) < count;
  assign swap     = cur > $signed(mem_rdata);

  always_comb begin
    state_next = state;
    unique case (state)
      cas_pkg::ST_IDLE: begin
        if (in_valid && in_item.last) begin
          state_next = cas_pkg::ST_RD_I;
        end
      end
      cas_pkg::ST_RD_I: begin
        state_next = cas_pkg::ST_LD_I;
      end
      cas_pkg::ST_LD_I: begin
        state_next = i_more ? cas_pkg::ST_SCAN : cas_pkg::ST_EMIT;
      end
      cas_pkg::ST_SCAN: begin
        state_next = j_more ? cas_pkg::ST_SCAN : cas_pkg::ST_EMIT;
      end
      cas_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = i_final ? cas_pkg::ST_IDLE : cas_pkg::ST_RD_I;
        end
      end
      default: state_next = cas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    count_next     = count;
    dropped_next   = dropped;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    cur_next       = cur;
    out_valid_next = out_valid && !out_ready;
    out_item_next  = out_item;
    mem_we         = 1'b0;
    mem_waddr      = idx_j;
    mem_wdata      = cur;
    mem_raddr      = idx_i;
    unique case (state)
      cas_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (count < CW'(MAX_ELEMENTS)) begin
            mem_we     = 1'b1;
            mem_waddr  = count[AW-1:0];
            mem_wdata  = in_item.value;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          idx_i_next = '0;
        end
      end
      cas_pkg::ST_RD_I: begin
        mem_raddr = idx_i;
      end
      cas_pkg::ST_LD_I: begin
        cur_next   = mem_rdata;
        mem_raddr  = idx_i + AW'(1);
        idx_j_next = idx_i + AW'(1);
      end
      cas_pkg::ST_SCAN: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = idx_j;
          mem_wdata = cur;
          cur_next  = mem_rdata;
        end
        mem_raddr  = idx_j + AW'(1);
        idx_j_next = idx_j + AW'(1);
      end
      cas_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_item_next.sorted_value  = cur;
          out_item_next.last_res      = i_final;
          out_item_next.overflow      = dropped;
          if (i_final) begin
            count_next   = '0;
            dropped_next = 1'b0;
          end else begin
            idx_i_next = idx_i + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cas_pkg::ST_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_i    <= idx_i_next;
    idx_j    <= idx_j_next;
    cur      <= cur_next;
    out_item <= out_item_next;
  end

endmodule

// File: design/concat_and_sort.sv
// Operation: an item that is not last is stored as it is taken. For a set of
//   stored values the last item starts the sort, one store read per cycle
//   through a single signed comparator; results leave as sorted.
// Flow: one set at a time, input not ready while the set is sorted and
//   emitted; an output stall holds the sequencer in its emit state.
// Reset: synchronous, active high; clears the element count and the drop flag.
// ----------------------------------------------------------------------------
// concat_and_sort: top level
// Collects signed values of a combined list and returns them in ascending
// order once the last one arrives.
// ----------------------------------------------------------------------------
module concat_and_sort #(
  parameter int MAX_ELEMENTS = cas_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cas_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cas_pkg::out_item_t out_item
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [cas_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [cas_pkg::DATA_W-1:0] mem_rdata;

  cas_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cas_store #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
